// File: src/assert_macros.svh
// Assertion helpers used by the checker file bba_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent, checked at every rising edge out of reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Expression must never hold at a rising edge out of reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Constants, codes and helper functions for the block bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

  localparam int MAP_BLOCKS = 256;
  localparam int MAX_RUN    = 64;
  localparam int ROW_BITS   = 8;
  localparam int NUM_ROWS   = MAP_BLOCKS / ROW_BITS;
  localparam int BLK_W      = $clog2(MAP_BLOCKS);
  localparam int BIT_W      = $clog2(ROW_BITS);
  localparam int ROW_AW     = $clog2(NUM_ROWS);
  localparam int CNT_W      = 7;
  localparam int REG_W      = 8;

  localparam logic [REG_W-1:0] BASE_RESET = 8'd6;
  localparam logic [REG_W-1:0] SIZE_RESET = 8'd250;
  localparam logic [7:0]       FREE_RESET = 8'd250;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic {
    REG_REGION_BASE = 1'b0,
    REG_REGION_SIZE = 1'b1
  } reg_index_t;

  // First allocatable block: block 0 is the failure code.
  function automatic logic [BLK_W-1:0] region_lo(logic [REG_W-1:0] base);
    region_lo = (base == '0) ? BLK_W'(1) : base;
  endfunction

  // One past the last allocatable block, clipped to the map end.
  function automatic logic [BLK_W:0] region_hi(logic [REG_W-1:0] base,
                                               logic [REG_W-1:0] size);
    logic [BLK_W:0] sum;
    sum = {1'b0, base} + {1'b0, size};
    region_hi = (sum > (BLK_W+1)'(MAP_BLOCKS)) ? (BLK_W+1)'(MAP_BLOCKS) : sum;
  endfunction

  // Bits of one bitmap row that fall inside [lo, hi).
  function automatic logic [ROW_BITS-1:0] region_mask(logic [ROW_AW-1:0] row,
                                                      logic [BLK_W-1:0] lo,
                                                      logic [BLK_W:0]   hi);
    logic [ROW_BITS-1:0] m;
    logic [BLK_W:0]      idx;
    for (int b = 0; b < ROW_BITS; b++) begin
      idx  = {1'b0, row, BIT_W'(b)};
      m[b] = (idx >= {1'b0, lo}) && (idx < hi);
    end
    region_mask = m;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_bit(logic [ROW_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (v[b]) begin
        r = BIT_W'(b);
      end
    end
    lowest_bit = r;
  endfunction

  function automatic logic [BIT_W:0] popcount_row(logic [ROW_BITS-1:0] v);
    logic [BIT_W:0] n;
    n = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      n = n + (BIT_W+1)'(v[b]);
    end
    popcount_row = n;
  endfunction

endpackage

// File: src/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// Used-block bitmap with lowest-free-first allocation and a free counter.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a request beat is taken when start is high and busy low.
//   func 0 allocates count blocks, func 1 frees block_index.
//   Results leave one beat per cycle at most, marked by result_valid for a
//   single cycle; the receiver cannot stall them. last flags the final beat.
//   Allocate: a counting pass reads the bitmap rows of the region, one a
//   cycle, with busy high. Then rows are visited in order from the region
//   start: each row is read (S_AWAIT) and its free blocks are granted
//   lowest first (S_ABIT). Each beat shows the cycle after its grant.
//   Bad count: one no_space beat the next cycle, busy stays low. Too little
//   space: one no_space beat the cycle after the counting pass.
//   Free: the row is read on accept, checked in S_FCHK, and the beat registered.
//   Config: plain write port; a write of region_size rescans the region to
//   reload the free counter, busy being high during the rescan.
//   Reset: bitmap reads as all clear at once (per-row written flags), free
//   counter 250, region base 6 and size 250. No clearing pass.
//   Rate is set by the row-wide bitmap memory and its registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_bitmap_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [bba_pkg::CNT_W-1:0]   count,
  input  logic [bba_pkg::BLK_W-1:0]   block_index,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [bba_pkg::REG_W-1:0]   cfg_wdata,
  output logic                        result_valid,
  output logic [bba_pkg::BLK_W-1:0]   block_number,
  output logic [1:0]                  status,
  output logic                        last,
  output logic [7:0]                  free_blocks
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECOUNT,
    S_COUNT,
    S_AWAIT,
    S_ABIT,
    S_FCHK
  } state_t;

  state_t state;

  logic [bba_pkg::REG_W-1:0] region_base;
  logic [bba_pkg::REG_W-1:0] region_size;
  logic [7:0]                free_counter;

  // bitmap memory
  logic [bba_pkg::ROW_BITS-1:0] map_mem [bba_pkg::NUM_ROWS];
  logic [bba_pkg::NUM_ROWS-1:0] row_written;
  logic [bba_pkg::ROW_BITS-1:0] rd_word;
  logic                         rd_row_ok;
  logic [bba_pkg::ROW_BITS-1:0] map_word;
  logic                         rd_en;
  logic [bba_pkg::ROW_AW-1:0]   rd_addr;
  logic                         wr_en;
  logic [bba_pkg::ROW_AW-1:0]   wr_addr;
  logic [bba_pkg::ROW_BITS-1:0] wr_data;

  // region scan
  logic [bba_pkg::BLK_W-1:0]    scan_lo;
  logic [bba_pkg::BLK_W:0]      scan_hi;
  logic [bba_pkg::BLK_W:0]      scan_hi_last;
  logic                         scan_init;
  logic                         scan_issue;
  logic                         scan_rd_vld;
  logic [bba_pkg::ROW_AW-1:0]   scan_addr;
  logic [bba_pkg::ROW_AW-1:0]   scan_rd_row;
  logic [bba_pkg::ROW_AW-1:0]   scan_row_hi;
  logic                         scan_empty;
  logic                         scan_done;
  logic [7:0]                   accum;
  logic [bba_pkg::BIT_W:0]      row_free;

  // request
  logic [bba_pkg::CNT_W-1:0]    cnt_req;
  logic [bba_pkg::CNT_W-1:0]    rem;
  logic [bba_pkg::BLK_W-1:0]    fidx;
  logic [bba_pkg::ROW_AW-1:0]   arow;
  logic [bba_pkg::ROW_BITS-1:0] wword;
  logic                         enough;
  logic                         bad_count;

  logic [bba_pkg::BLK_W-1:0]    reg_lo;
  logic [bba_pkg::BLK_W:0]      reg_hi;

  // allocation step
  logic [bba_pkg::ROW_BITS-1:0] a_free;
  logic                         a_any;
  logic [bba_pkg::BIT_W-1:0]    a_bit;
  logic [bba_pkg::ROW_BITS-1:0] a_hot;
  logic [bba_pkg::ROW_BITS-1:0] a_new;
  logic                         a_finish;
  logic                         a_end;

  // free check
  logic [bba_pkg::ROW_BITS-1:0] f_hot;
  logic                         f_ok;

  logic [7:0]                   cnt_dec;
  logic [7:0]                   cnt_inc;

  assign busy = (state != S_IDLE);

  always_comb begin
    reg_lo       = bba_pkg::region_lo(region_base);
    reg_hi       = bba_pkg::region_hi(region_base, region_size);
    map_word     = rd_row_ok ? rd_word : '0;

    scan_hi_last = scan_hi - (bba_pkg::BLK_W+1)'(1);
    scan_row_hi  = scan_hi_last[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
    scan_empty   = ({1'b0, scan_lo} >= scan_hi);
    scan_done    = !scan_init && !scan_issue && !scan_rd_vld;
    row_free     = bba_pkg::popcount_row(~map_word &
                     bba_pkg::region_mask(scan_rd_row, scan_lo, scan_hi));
    enough       = !(accum < {1'b0, cnt_req});
    bad_count    = (count == '0) || (count > bba_pkg::CNT_W'(bba_pkg::MAX_RUN));

    a_free   = ~wword & bba_pkg::region_mask(arow, reg_lo, reg_hi);
    a_any    = (a_free != '0);
    a_bit    = bba_pkg::lowest_bit(a_free);
    a_hot    = a_any ? (bba_pkg::ROW_BITS'(1) << a_bit) : '0;
    a_new    = wword | a_hot;
    a_finish = !a_any || ((a_free & ~a_hot) == '0) || (rem == bba_pkg::CNT_W'(1));
    a_end    = a_any && (rem == bba_pkg::CNT_W'(1));

    f_hot = bba_pkg::ROW_BITS'(1) << fidx[bba_pkg::BIT_W-1:0];
    f_ok  = (fidx >= reg_lo) && ({1'b0, fidx} < reg_hi) && ((map_word & f_hot) != '0);

    cnt_dec = (free_counter == 8'd0)   ? 8'd0   : free_counter - 8'd1;
    cnt_inc = (free_counter == 8'd255) ? 8'd255 : free_counter + 8'd1;
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      S_IDLE: begin
        if (start && func) begin
          rd_en   = 1'b1;
          rd_addr = block_index[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
        end
      end
      S_RECOUNT: begin
        rd_en   = scan_issue;
        rd_addr = scan_addr;
      end
      S_COUNT: begin
        if (scan_issue) begin
          rd_en   = 1'b1;
          rd_addr = scan_addr;
        end else if (scan_done && enough) begin
          rd_en   = 1'b1;
          rd_addr = reg_lo[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
        end
      end
      S_ABIT: begin
        if (a_any && a_finish) begin
          wr_en   = 1'b1;
          wr_addr = arow;
          wr_data = a_new;
        end
        if (a_finish && !a_end) begin
          rd_en   = 1'b1;
          rd_addr = arow + bba_pkg::ROW_AW'(1);
        end
      end
      S_FCHK: begin
        if (f_ok) begin
          wr_en   = 1'b1;
          wr_addr = fidx[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
          wr_data = map_word & ~f_hot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word   <= map_mem[rd_addr];
      rd_row_ok <= row_written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      region_base  <= bba_pkg::BASE_RESET;
      region_size  <= bba_pkg::SIZE_RESET;
      free_counter <= bba_pkg::FREE_RESET;
      row_written  <= '0;
      result_valid <= 1'b0;
      scan_init    <= 1'b0;
      scan_issue   <= 1'b0;
      scan_rd_vld  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (wr_en) begin
        row_written[wr_addr] <= 1'b1;
      end

      // scan pipeline: issue one row a cycle, add its clear bits in the next cycle
      scan_rd_vld <= scan_issue;
      scan_rd_row <= scan_addr;
      if (scan_issue) begin
        if (scan_addr == scan_row_hi) begin
          scan_issue <= 1'b0;
        end else begin
          scan_addr <= scan_addr + bba_pkg::ROW_AW'(1);
        end
      end
      if (scan_rd_vld) begin
        accum <= accum + 8'(row_free);
      end
      if (scan_init) begin
        scan_init  <= 1'b0;
        scan_addr  <= scan_lo[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
        scan_issue <= !scan_empty;
        accum      <= '0;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            if (func) begin
              fidx  <= block_index;
              state <= S_FCHK;
            end else if (bad_count) begin
              result_valid <= 1'b1;
              block_number <= '0;
              status       <= bba_pkg::ST_NO_SPACE;
              last         <= 1'b1;
              free_blocks  <= free_counter;
            end else begin
              cnt_req   <= count;
              rem       <= count;
              scan_lo   <= reg_lo;
              scan_hi   <= reg_hi;
              scan_init <= 1'b1;
              state     <= S_COUNT;
            end
          end
        end
        S_RECOUNT: begin
          if (scan_done) begin
            free_counter <= accum;
            state        <= S_IDLE;
          end
        end
        S_COUNT: begin
          if (scan_done) begin
            if (!enough) begin
              result_valid <= 1'b1;
              block_number <= '0;
              status       <= bba_pkg::ST_NO_SPACE;
              last         <= 1'b1;
              free_blocks  <= free_counter;
              state        <= S_IDLE;
            end else begin
              arow  <= reg_lo[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
              state <= S_AWAIT;
            end
          end
        end
        S_AWAIT: begin
          wword <= map_word;
          state <= S_ABIT;
        end
        S_ABIT: begin
          if (a_any) begin
            wword        <= a_new;
            result_valid <= 1'b1;
            block_number <= {arow, a_bit};
            status       <= bba_pkg::ST_OK;
            last         <= (rem == bba_pkg::CNT_W'(1));
            free_blocks  <= cnt_dec;
            free_counter <= cnt_dec;
            rem          <= rem - bba_pkg::CNT_W'(1);
          end
          if (a_finish) begin
            if (a_end) begin
              state <= S_IDLE;
            end else begin
              arow  <= arow + bba_pkg::ROW_AW'(1);
              state <= S_AWAIT;
            end
          end
        end
        S_FCHK: begin
          result_valid <= 1'b1;
          last         <= 1'b1;
          if (f_ok) begin
            block_number <= fidx;
            status       <= bba_pkg::ST_OK;
            free_blocks  <= cnt_inc;
            free_counter <= cnt_inc;
          end else begin
            block_number <= '0;
            status       <= bba_pkg::ST_INVALID;
            free_blocks  <= free_counter;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // a size write reloads the counter from the region as it stands now
      if (cfg_we) begin
        case (cfg_addr)
          bba_pkg::REG_REGION_BASE: begin
            region_base <= cfg_wdata;
          end
          bba_pkg::REG_REGION_SIZE: begin
            region_size <= cfg_wdata;
            scan_lo     <= reg_lo;
            scan_hi     <= bba_pkg::region_hi(region_base, cfg_wdata);
            scan_init   <= 1'b1;
            scan_issue  <= 1'b0;
            scan_rd_vld <= 1'b0;
            state       <= S_RECOUNT;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: src/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the block bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bba_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        func,
  input logic                        result_valid,
  input logic [bba_pkg::BLK_W-1:0]   block_number,
  input logic [1:0]                  status,
  input logic                        last,
  input logic [7:0]                  free_blocks
);

  // failed beats carry block 0 and close the request
  `ASSERT_IMPL(a_fail_beat, clk, rst,
    result_valid && (status == bba_pkg::ST_NO_SPACE || status == bba_pkg::ST_INVALID),
    block_number == '0 && last,
    "failed beat with block or without last")

  // a good beat never hands out the failure code
  `ASSERT_NEVER(a_ok_nonzero, clk, rst,
    result_valid && status == bba_pkg::ST_OK && block_number == '0,
    "ok beat with block 0")

  // a free request answers with a result beat that carries last
  `ASSERT_IMPL(a_free_latency, clk, rst,
    start && !busy && func,
    ##2 (result_valid && last),
    "free result missing or late")

  // within one allocate run, back-to-back beats step the counter down by one
  `ASSERT_IMPL(a_run_count, clk, rst,
    result_valid && status == bba_pkg::ST_OK && $past(result_valid) &&
      $past(status) == bba_pkg::ST_OK && !$past(last),
    free_blocks == (($past(free_blocks) == 8'd0) ? 8'd0 : $past(free_blocks) - 8'd1),
    "free count not stepping within a run")

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (.*);
